// ===== rtl/swcl_pkg.sv =====
package swcl_pkg;

  // Address space and list limits.
  localparam int ADDR_W       = 19;
  localparam int CNT_W        = 12;
  localparam int MAX_COMMANDS = 2000;
  localparam int TABLE_STRIDE = 32;

  // Request kinds.
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_CMD   = 1'b1;

  // Jump modes from control bits 13:12.
  localparam logic [1:0] JMP_NEXT   = 2'd0;
  localparam logic [1:0] JMP_ASSIGN = 2'd1;
  localparam logic [1:0] JMP_CALL   = 2'd2;
  localparam logic [1:0] JMP_RETURN = 2'd3;

  // Draw operation codes.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_NORMAL    = 4'd1;
  localparam logic [3:0] OP_SCALED    = 4'd2;
  localparam logic [3:0] OP_DISTORTED = 4'd3;
  localparam logic [3:0] OP_POLYGON   = 4'd4;
  localparam logic [3:0] OP_POLYLINE  = 4'd5;
  localparam logic [3:0] OP_LINE      = 4'd6;
  localparam logic [3:0] OP_USER_CLIP = 4'd7;
  localparam logic [3:0] OP_SYS_CLIP  = 4'd8;
  localparam logic [3:0] OP_LOCAL     = 4'd9;
  localparam logic [3:0] OP_BAD       = 4'd10;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PLOT_TRIGGER   = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_ON     = 2'd1;
  localparam logic [1:0] CFG_DISPLAY_TOGGLE = 2'd2;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] plot_trigger;
    logic       display_on;
    logic       display_toggle;
  } swcl_cfg_t;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic              req_type;
    logic              end_bit;
    logic [1:0]        jmode;
    logic [3:0]        op;
    logic [ADDR_W-1:0] target;
  } swcl_entry_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QPTR_W:0] count;
  } swcl_q_stat_t;

  // Command code to draw operation.
  function automatic logic [3:0] op_of_code(input logic [3:0] code);
    logic [3:0] op;
    case (code)
      4'd0:    op = OP_NORMAL;
      4'd1:    op = OP_SCALED;
      4'd2:    op = OP_DISTORTED;
      4'd4:    op = OP_POLYGON;
      4'd5:    op = OP_POLYLINE;
      4'd6:    op = OP_LINE;
      4'd8:    op = OP_USER_CLIP;
      4'd9:    op = OP_SYS_CLIP;
      4'd10:   op = OP_LOCAL;
      default: op = OP_BAD;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/swcl_in_if.sv =====
interface swcl_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] cmd_control;
  logic [15:0] cmd_link;

  modport source (output valid, req_type, cmd_control, cmd_link, input ready);
  modport sink   (input valid, req_type, cmd_control, cmd_link, output ready);
endinterface

// ===== rtl/swcl_out_if.sv =====
interface swcl_out_if;
  logic                       valid;
  logic                       ready;
  logic [3:0]                 draw_op;
  logic [swcl_pkg::ADDR_W-1:0] fetch_addr;
  logic                       list_done;
  logic                       draw_end_irq;
  logic [1:0]                 end_status;

  modport source (output valid, draw_op, fetch_addr, list_done, draw_end_irq, end_status,
                  input ready);
  modport sink   (input valid, draw_op, fetch_addr, list_done, draw_end_irq, end_status,
                  output ready);
endinterface

// ===== rtl/swcl_front.sv =====
module swcl_front (
  swcl_in_if.sink             in_req,
  input  logic                q_full,
  output logic                push,
  output swcl_pkg::swcl_entry_t entry
);

  logic [31:0] link_scaled;

  // Accept whenever the queue has room.
  assign in_req.ready = !q_full;
  assign push         = in_req.valid && !q_full;

  // The jump target is the link word times eight, wrapped to the address space.
  assign link_scaled = {13'd0, in_req.cmd_link, 3'b000};

  // Classify the request; a skipped table draws nothing.
  always_comb begin
    entry.req_type = in_req.req_type;
    entry.end_bit  = in_req.cmd_control[15];
    entry.jmode    = in_req.cmd_control[13:12];
    entry.op       = in_req.cmd_control[14] ? swcl_pkg::OP_NONE
                                            : swcl_pkg::op_of_code(in_req.cmd_control[3:0]);
    entry.target   = link_scaled[swcl_pkg::ADDR_W-1:0];
  end

endmodule

// ===== rtl/swcl_queue.sv =====
module swcl_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  swcl_pkg::swcl_entry_t push_entry,
  input  logic                  pop,
  output swcl_pkg::swcl_entry_t head,
  output swcl_pkg::swcl_q_stat_t stat
);

  swcl_pkg::swcl_entry_t             mem_r [swcl_pkg::QUEUE_DEPTH];
  logic [swcl_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [swcl_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [swcl_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign stat.full  = (count_r == (swcl_pkg::QPTR_W+1)'(swcl_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign head       = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/swcl_back.sv =====
module swcl_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swcl_pkg::swcl_cfg_t    cfg,
  input  swcl_pkg::swcl_q_stat_t q_stat,
  input  swcl_pkg::swcl_entry_t  head,
  output logic                   pop,
  swcl_out_if.source             out_res
);

  localparam int AW = swcl_pkg::ADDR_W;

  logic [AW-1:0]                table_addr_r, table_addr_nxt;
  logic [AW-1:0]                return_addr_r, return_addr_nxt;
  logic                         return_valid_r, return_valid_nxt;
  logic [swcl_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                         active_r, active_nxt;
  logic [1:0]                   end_flags_r, end_flags_nxt;

  logic                         out_valid_r;
  logic [3:0]                   op_r, op_nxt;
  logic                         done_r, done_nxt;
  logic                         irq_r, irq_nxt;

  logic                         enabled;
  logic                         at_limit;
  logic [AW-1:0]                following;

  // Take the next request when the output register is free or being drained.
  assign pop = !q_stat.empty && (!out_valid_r || out_res.ready);

  assign enabled   = (cfg.plot_trigger != 2'd0) && cfg.display_on && cfg.display_toggle;
  assign at_limit  = (count_r >= swcl_pkg::CNT_W'(swcl_pkg::MAX_COMMANDS));
  assign following = table_addr_r + AW'(swcl_pkg::TABLE_STRIDE);

  // List walk: frame start, end detection and next-address choice.
  always_comb begin
    table_addr_nxt   = table_addr_r;
    return_addr_nxt  = return_addr_r;
    return_valid_nxt = return_valid_r;
    count_nxt        = count_r;
    active_nxt       = active_r;
    end_flags_nxt    = end_flags_r;
    op_nxt           = swcl_pkg::OP_NONE;
    done_nxt         = 1'b1;
    irq_nxt          = 1'b0;
    if (head.req_type == swcl_pkg::REQ_FRAME) begin
      if (!enabled) begin
        active_nxt = 1'b0;
      end else begin
        table_addr_nxt   = '0;
        return_addr_nxt  = '0;
        return_valid_nxt = 1'b0;
        count_nxt        = '0;
        end_flags_nxt    = {1'b0, end_flags_r[1]};
        active_nxt       = 1'b1;
        done_nxt         = 1'b0;
      end
    end else if (active_r) begin
      if (head.end_bit || at_limit) begin
        end_flags_nxt = {1'b1, end_flags_r[0]};
        active_nxt    = 1'b0;
        irq_nxt       = 1'b1;
      end else begin
        op_nxt   = head.op;
        done_nxt = 1'b0;
        case (head.jmode)
          swcl_pkg::JMP_NEXT: begin
            table_addr_nxt = following;
          end
          swcl_pkg::JMP_ASSIGN: begin
            table_addr_nxt = head.target;
          end
          swcl_pkg::JMP_CALL: begin
            if (!return_valid_r) begin
              return_addr_nxt  = following;
              return_valid_nxt = 1'b1;
            end
            table_addr_nxt = head.target;
          end
          default: begin
            if (return_valid_r) begin
              table_addr_nxt   = return_addr_r;
              return_valid_nxt = 1'b0;
            end else begin
              table_addr_nxt = following;
            end
          end
        endcase
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // Walker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_addr_r   <= '0;
      return_addr_r  <= '0;
      return_valid_r <= 1'b0;
      count_r        <= '0;
      active_r       <= 1'b0;
      end_flags_r    <= '0;
    end else if (pop) begin
      table_addr_r   <= table_addr_nxt;
      return_addr_r  <= return_addr_nxt;
      return_valid_r <= return_valid_nxt;
      count_r        <= count_nxt;
      active_r       <= active_nxt;
      end_flags_r    <= end_flags_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r   <= op_nxt;
      done_r <= done_nxt;
      irq_r  <= irq_nxt;
    end
  end

  // Address and end status in the result are the state after the request.
  assign out_res.valid        = out_valid_r;
  assign out_res.draw_op      = op_r;
  assign out_res.fetch_addr   = table_addr_r;
  assign out_res.list_done    = done_r;
  assign out_res.draw_end_irq = irq_r;
  assign out_res.end_status   = end_flags_r;

endmodule

// ===== rtl/sprite_command_list_walker_unit.sv =====
// Sprite command list walker.
// Requests arrive on in_req (valid/ready): a frame start, or the control and
// link words of one fetched command table. Each request gives exactly one
// result on out_res (valid/ready): the draw operation, the byte address of the
// next table to fetch, the list-done and draw-end flags and the end status.
// The cfg_we/cfg_index/cfg_wdata port writes plot trigger, display enable and
// display toggle; write it only while no request is in flight.
// A front stage classifies each request into a four-entry queue; a back stage
// walks the list and loads the output register. One request per cycle is
// sustained while out_res.ready is high. A request goes into the queue, then
// into the output register. The back stage's state update sets that rate.
// Reset clears the queue, the output valid flag and the walker state (idle,
// all addresses and flags zero); the display toggle resets to one. When the
// receiver stalls the result holds, the back stage waits and the queue fills;
// in_req.ready drops once four requests are queued.
module sprite_command_list_walker_unit (
  input  logic       clk,
  input  logic       rst_n,
  swcl_in_if.sink    in_req,
  swcl_out_if.source out_res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_wdata
);

  swcl_pkg::swcl_cfg_t    cfg_r;
  swcl_pkg::swcl_entry_t  push_entry;
  swcl_pkg::swcl_entry_t  head;
  swcl_pkg::swcl_q_stat_t q_stat;
  logic                   push;
  logic                   pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plot_trigger   <= 2'd0;
      cfg_r.display_on     <= 1'b0;
      cfg_r.display_toggle <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        swcl_pkg::CFG_PLOT_TRIGGER:   cfg_r.plot_trigger   <= cfg_wdata;
        swcl_pkg::CFG_DISPLAY_ON:     cfg_r.display_on     <= cfg_wdata[0];
        swcl_pkg::CFG_DISPLAY_TOGGLE: cfg_r.display_toggle <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  swcl_front u_front (
    .in_req (in_req),
    .q_full (q_stat.full),
    .push   (push),
    .entry  (push_entry)
  );

  swcl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  swcl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .head    (head),
    .pop     (pop),
    .out_res (out_res)
  );

  // The back stage never takes a request from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A draw-end result always closes the list.
  a_irq_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.draw_end_irq) |-> out_res.list_done)
    else $error("draw-end without list done");

  // A draw-end result always shows the current-end flag.
  a_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.draw_end_irq) |-> out_res.end_status[1])
    else $error("draw-end without end flag");

  // A push without a pop raises the queue occupancy by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule
